>>> rtl/core/ppls_pkg.sv
// Shared constants, widths and types for the point-light Phong shading pipeline.
// No dependencies; every other file of the block imports this package.
package ppls_pkg;

    localparam int FRAC_BITS = 14;          // fraction bits of unit and color values
    localparam int POS_FRAC  = 8;           // fraction bits of positions
    localparam int CW        = 16;          // width of one field or one third of a packed register

    // light vector and its length
    localparam int DW    = CW + 1;                  // light minus point
    localparam int SQW   = 2 * DW - 1;              // one squared component
    localparam int SUMW  = 2 * DW;                  // sum of three squares
    localparam int RADW  = SUMW + 2 * POS_FRAC;     // radicand of the length
    localparam int ROOTW = RADW / 2;                // length
    localparam int REMW  = ROOTW + 2;               // partial remainder of the root
    localparam int SQRT_STEPS = ROOTW;

    // normalization divide
    localparam int QW   = FRAC_BITS + 1;            // quotient, at most 1.0
    localparam int DIVW = DW + FRAC_BITS + POS_FRAC;// dividend
    localparam int CMPW = DIVW + 1;
    localparam int LW   = QW + 1;                   // signed light direction component

    // dot products and reflection
    localparam int LNW   = LW + CW;
    localparam int DLNW  = LNW + 2 - FRAC_BITS;
    localparam int NDLW  = 17;                      // clamped N.L
    localparam int MW    = CW + DLNW + 1;
    localparam int RW    = MW - FRAC_BITS + 1;
    localparam int PEW   = RW + CW;
    localparam int DREW  = PEW + 2 - FRAC_BITS;

    // power and color terms
    localparam int SATW      = FRAC_BITS + 2;
    localparam int SHIN_W    = 8;
    localparam int POW_STEPS = (1 << SHIN_W) - 1;
    localparam int EFFW      = 2 * CW - FRAC_BITS;
    localparam int AMBW      = EFFW + CW - FRAC_BITS;
    localparam int TW        = NDLW + EFFW - FRAC_BITS;
    localparam int SPW       = EFFW + SATW - FRAC_BITS;
    localparam int DIFW      = TW + CW - FRAC_BITS;
    localparam int TOTW      = DIFW + 2;

    localparam logic [SATW-1:0] SAT_MAX = {SATW{1'b1}};
    localparam logic [SATW-1:0] ONE_Q   = SATW'(1 << FRAC_BITS);
    localparam logic [CW-1:0]   OUT_MAX = {CW{1'b1}};

    // configuration port
    localparam int PAW = 6;
    localparam int PDW = 64;
    localparam int PKW = 3 * CW;

    typedef enum logic [2:0] {
        REG_LIGHT_POS  = 3'd0,
        REG_INTENSITY  = 3'd1,
        REG_COLOR      = 3'd2,
        REG_AMBIENT    = 3'd3,
        REG_DIFFUSE    = 3'd4,
        REG_SPECULAR   = 3'd5,
        REG_SHININESS  = 3'd6
    } reg_idx_t;

    localparam logic [PKW-1:0]    RST_LIGHT_POS = '0;
    localparam logic [PKW-1:0]    RST_UNIT3     = {3{ONE_Q}};
    localparam logic [CW-1:0]     RST_AMBIENT   = 16'd1638;
    localparam logic [CW-1:0]     RST_DIFFUSE   = 16'd14746;
    localparam logic [CW-1:0]     RST_SPECULAR  = 16'd14746;
    localparam logic [SHIN_W-1:0] RST_SHININESS = 8'd200;

    typedef struct packed {
        logic [2:0][CW-1:0] n;
        logic [2:0][CW-1:0] e;
    } dir_t;

    typedef struct packed {
        logic [2:0][CW-1:0]   light_pos;
        logic [2:0][EFFW-1:0] eff;
        logic [2:0][AMBW-1:0] amb;
        logic [2:0][EFFW-1:0] spg;
        logic [CW-1:0]        diffuse;
        logic [SHIN_W-1:0]    shininess;
    } cfg_t;

endpackage

>>> rtl/core/phong_point_light_shading.sv
// Top level of the point-light Phong shading pipeline.
// Depends on ppls_pkg, ppls_cfg, ppls_norm, ppls_dir, ppls_pow and ppls_out.
//
// Usage:
//   Input channel: point, normal and eye fields with in_valid / in_stall. A beat
//   is taken on a rising edge with in_valid high and in_stall low.
//   Output channel: shade_red/green/blue with out_valid / out_stall.
//   Configuration: APB-style 64-bit port, register i at byte address 8*i.
//   pready is tied high; reads return the stored value.
// Throughput: one beat per cycle while the pipeline is not held by a stall.
// Stages: 28 for the light vector and its square root (one root bit per
//   stage), 23 for the 15-bit divide and the dot products, 255 for the
//   specular power (one multiply per stage), and 3 for the color terms
//   and the output register.
// Stall: an output register plus one skid slot; the whole pipeline holds
//   only once the skid is full, and in_stall is that registered flag.
// Reset: clears all valid bits and loads the register defaults; the block
//   accepts beats in the first cycle after reset is released.
module phong_point_light_shading
    import ppls_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           in_valid,
    output logic           in_stall,
    input  logic [15:0]    point_x,
    input  logic [15:0]    point_y,
    input  logic [15:0]    point_z,
    input  logic [15:0]    normal_x,
    input  logic [15:0]    normal_y,
    input  logic [15:0]    normal_z,
    input  logic [15:0]    eye_x,
    input  logic [15:0]    eye_y,
    input  logic [15:0]    eye_z,

    output logic           out_valid,
    input  logic           out_stall,
    output logic [15:0]    shade_red,
    output logic [15:0]    shade_green,
    output logic [15:0]    shade_blue,

    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready
);

    cfg_t               cfg;
    logic               en;
    logic [2:0][CW-1:0] point;
    dir_t               dir_in;

    logic               nv;
    logic [ROOTW-1:0]   len;
    logic [2:0][DW-1:0] d_vec;
    dir_t               dir_n;

    logic               dv;
    logic [SATW-1:0]    red;
    logic [NDLW-1:0]    ndl_d;

    logic               pv;
    logic [SATW-1:0]    factor;
    logic [NDLW-1:0]    ndl_p;

    logic [2:0][CW-1:0] shade;

    assign pready   = 1'b1;
    assign in_stall = !en;

    assign point    = {point_z, point_y, point_x};
    assign dir_in.n = {normal_z, normal_y, normal_x};
    assign dir_in.e = {eye_z, eye_y, eye_x};

    ppls_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ppls_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid && en),
        .point     (point),
        .dir_in    (dir_in),
        .light_pos (cfg.light_pos),
        .out_valid (nv),
        .len       (len),
        .d_out     (d_vec),
        .dir_out   (dir_n)
    );

    ppls_dir u_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv),
        .len       (len),
        .d_in      (d_vec),
        .dir_in    (dir_n),
        .out_valid (dv),
        .red       (red),
        .ndl       (ndl_d)
    );

    ppls_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .shininess (cfg.shininess),
        .in_valid  (dv),
        .red       (red),
        .ndl_in    (ndl_d),
        .out_valid (pv),
        .factor    (factor),
        .ndl_out   (ndl_p)
    );

    ppls_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pv),
        .factor    (factor),
        .ndl       (ndl_p),
        .out_stall (out_stall),
        .en        (en),
        .out_valid (out_valid),
        .shade     (shade)
    );

    assign shade_red   = shade[0];
    assign shade_green = shade[1];
    assign shade_blue  = shade[2];

endmodule

>>> rtl/core/ppls_cfg.sv
// Configuration registers behind the APB-style port, plus the per-channel
// terms that depend on registers only. Uses ppls_pkg.
module ppls_cfg
    import ppls_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output cfg_t           cfg
);

    logic [PKW-1:0]    light_pos_reg;
    logic [PKW-1:0]    intensity_reg;
    logic [PKW-1:0]    color_reg;
    logic [CW-1:0]     ambient_reg;
    logic [CW-1:0]     diffuse_reg;
    logic [CW-1:0]     specular_reg;
    logic [SHIN_W-1:0] shininess_reg;

    logic [2:0][EFFW-1:0] eff_reg;
    logic [2:0][AMBW-1:0] amb_reg;
    logic [2:0][EFFW-1:0] spg_reg;

    logic [2:0][2*CW-1:0]    eff_prod;
    logic [2:0][2*CW-1:0]    spg_prod;
    logic [2:0][EFFW+CW-1:0] amb_prod;

    logic       wr;
    logic [2:0] idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[PAW-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pos_reg <= RST_LIGHT_POS;
            intensity_reg <= RST_UNIT3;
            color_reg     <= RST_UNIT3;
            ambient_reg   <= RST_AMBIENT;
            diffuse_reg   <= RST_DIFFUSE;
            specular_reg  <= RST_SPECULAR;
            shininess_reg <= RST_SHININESS;
        end
        else if (wr)
        begin
            case (idx)
                REG_LIGHT_POS: light_pos_reg <= pwdata[PKW-1:0];
                REG_INTENSITY: intensity_reg <= pwdata[PKW-1:0];
                REG_COLOR:     color_reg     <= pwdata[PKW-1:0];
                REG_AMBIENT:   ambient_reg   <= pwdata[CW-1:0];
                REG_DIFFUSE:   diffuse_reg   <= pwdata[CW-1:0];
                REG_SPECULAR:  specular_reg  <= pwdata[CW-1:0];
                REG_SHININESS: shininess_reg <= pwdata[SHIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LIGHT_POS: prdata = PDW'(light_pos_reg);
            REG_INTENSITY: prdata = PDW'(intensity_reg);
            REG_COLOR:     prdata = PDW'(color_reg);
            REG_AMBIENT:   prdata = PDW'(ambient_reg);
            REG_DIFFUSE:   prdata = PDW'(diffuse_reg);
            REG_SPECULAR:  prdata = PDW'(specular_reg);
            REG_SHININESS: prdata = PDW'(shininess_reg);
            default:       prdata = '0;
        endcase
    end

    // effective color and specular scale first, ambient from the registered effective color in the cycle after
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            eff_prod[c] = (2*CW)'(color_reg[c*CW +: CW]) * (2*CW)'(intensity_reg[c*CW +: CW]);
            spg_prod[c] = (2*CW)'(intensity_reg[c*CW +: CW]) * (2*CW)'(specular_reg);
            amb_prod[c] = (EFFW+CW)'(eff_reg[c]) * (EFFW+CW)'(ambient_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            eff_reg[c] <= eff_prod[c][FRAC_BITS +: EFFW];
            spg_reg[c] <= spg_prod[c][FRAC_BITS +: EFFW];
            amb_reg[c] <= amb_prod[c][FRAC_BITS +: AMBW];
        end
    end

    assign cfg.light_pos = light_pos_reg;
    assign cfg.eff       = eff_reg;
    assign cfg.amb       = amb_reg;
    assign cfg.spg       = spg_reg;
    assign cfg.diffuse   = diffuse_reg;
    assign cfg.shininess = shininess_reg;

endmodule

>>> rtl/core/ppls_norm.sv
// Light vector, squared length and a pipelined integer square root
// (two radicand bits per stage). Uses ppls_pkg.
module ppls_norm
    import ppls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0][CW-1:0] point,
    input  dir_t               dir_in,
    input  logic [2:0][CW-1:0] light_pos,
    output logic               out_valid,
    output logic [ROOTW-1:0]   len,
    output logic [2:0][DW-1:0] d_out,
    output dir_t               dir_out
);

    logic               v1_reg, v2_reg;
    logic [2:0][DW-1:0] d1_reg, d2_reg, d1_next;
    dir_t               dir1_reg, dir2_reg;
    logic [2:0][SQW-1:0] sq_reg, sq_next;
    logic signed [2*DW-1:0] sq_full [3];
    logic [SUMW-1:0]    sum_next;

    logic               v_reg    [SQRT_STEPS+1];
    logic [RADW-1:0]    rad_reg  [SQRT_STEPS+1];
    logic [REMW-1:0]    rem_reg  [SQRT_STEPS+1];
    logic [ROOTW-1:0]   root_reg [SQRT_STEPS+1];
    logic [2:0][DW-1:0] d_pipe   [SQRT_STEPS+1];
    dir_t               dir_pipe [SQRT_STEPS+1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1_next[k] = {light_pos[k][CW-1], light_pos[k]} - {point[k][CW-1], point[k]};
            sq_full[k] = $signed(d1_reg[k]) * $signed(d1_reg[k]);
            sq_next[k] = sq_full[k][SQW-1:0];
        end
        sum_next = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v_reg[0]  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg      <= d1_next;
            dir1_reg    <= dir_in;
            d2_reg      <= d1_reg;
            dir2_reg    <= dir1_reg;
            sq_reg      <= sq_next;
            rad_reg[0]  <= {sum_next, {(2*POS_FRAC){1'b0}}};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            d_pipe[0]   <= d2_reg;
            dir_pipe[0] <= dir2_reg;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [REMW+1:0] rem2;
        logic [REMW+1:0] trial;
        logic            ge;

        // bring down the next two radicand bits and try root*4+1
        assign rem2  = {rem_reg[j], rad_reg[j][RADW-1 -: 2]};
        assign trial = {2'b00, root_reg[j], 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? REMW'(rem2 - trial) : REMW'(rem2);
                root_reg[j+1] <= {root_reg[j][ROOTW-2:0], ge};
                rad_reg[j+1]  <= {rad_reg[j][RADW-3:0], 2'b00};
                d_pipe[j+1]   <= d_pipe[j];
                dir_pipe[j+1] <= dir_pipe[j];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS];
    assign len       = root_reg[SQRT_STEPS];
    assign d_out     = d_pipe[SQRT_STEPS];
    assign dir_out   = dir_pipe[SQRT_STEPS];

endmodule

>>> rtl/core/ppls_dir.sv
// Light direction by pipelined restoring divide, then N.L, reflection and R.E;
// N.L is clamped below at zero and R.E to [0, SAT_MAX]. Uses ppls_pkg.
module ppls_dir
    import ppls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [ROOTW-1:0]   len,
    input  logic [2:0][DW-1:0] d_in,
    input  dir_t               dir_in,
    output logic               out_valid,
    output logic [SATW-1:0]    red,
    output logic [NDLW-1:0]    ndl
);

    // divide stages: index 0 holds the prepared operands
    logic                 v_reg    [QW+1];
    logic [2:0][DIVW-1:0] rem_reg  [QW+1];
    logic [2:0][QW-1:0]   q_reg    [QW+1];
    logic [ROOTW-1:0]     len_reg  [QW+1];
    logic [2:0]           neg_reg  [QW+1];
    logic                 zero_reg [QW+1];
    dir_t                 dir_pipe [QW+1];

    logic [2:0][DW-1:0]   mag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            mag[k] = d_in[k][DW-1] ? DW'(-d_in[k]) : d_in[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= {mag[k], {(FRAC_BITS+POS_FRAC){1'b0}}};
                neg_reg[0][k] <= d_in[k][DW-1];
            end
            q_reg[0]    <= '0;
            len_reg[0]  <= len;
            zero_reg[0] <= (len == '0);
            dir_pipe[0] <= dir_in;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int SH = QW - 1 - s;
        logic [CMPW-1:0] dv;
        logic [2:0]      ge;

        assign dv = CMPW'(len_reg[s]) << SH;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
                ge[k] = CMPW'(rem_reg[s][k]) >= dv;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[s+1][k] <= ge[k] ? DIVW'(CMPW'(rem_reg[s][k]) - dv)
                                             : rem_reg[s][k];
                    q_reg[s+1][k]   <= {q_reg[s][k][QW-2:0], ge[k]};
                end
                len_reg[s+1]  <= len_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                dir_pipe[s+1] <= dir_pipe[s];
            end
        end
    end

    // post-divide stages
    logic                  vl_reg, vp1_reg, vp2_reg, vp3_reg, vp4_reg, vp5_reg, vp6_reg;
    logic [2:0][LW-1:0]    l_reg, l1_reg, l2_reg, l3_reg, l_next;
    dir_t                  dirl_reg, dir1_reg, dir2_reg;
    logic [2:0][CW-1:0]    e3_reg, e4_reg;
    logic [2:0][LNW-1:0]   ln_reg;
    logic signed [LNW-1:0] ln_next [3];
    logic signed [LNW+1:0] lsum;
    logic [DLNW-1:0]       dln_reg;
    logic signed [CW+DLNW-1:0] m_prod [3];
    logic [2:0][MW-1:0]    m_reg;
    logic [NDLW-1:0]       ndl3_reg, ndl4_reg, ndl5_reg, ndl6_reg, ndl_next;
    logic [2:0][RW-1:0]    r_reg, r_next;
    logic signed [PEW-1:0] pe_next [3];
    logic [2:0][PEW-1:0]   pe_reg;
    logic signed [PEW+1:0] esum;
    logic [DREW-1:0]       dre;
    logic [SATW-1:0]       red_next;
    logic [SATW-1:0]       red_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (zero_reg[QW])
                l_next[k] = '0;
            else if (neg_reg[QW][k])
                l_next[k] = LW'(-{1'b0, q_reg[QW][k]});
            else
                l_next[k] = {1'b0, q_reg[QW][k]};
            ln_next[k] = $signed(l_reg[k]) * $signed(dirl_reg.n[k]);
            m_prod[k]  = $signed(dir2_reg.n[k]) * $signed(dln_reg);
            r_next[k]  = RW'($signed(m_reg[k][MW-1:FRAC_BITS])) - RW'($signed(l3_reg[k]));
            pe_next[k] = $signed(r_reg[k]) * $signed(e4_reg[k]);
        end
        lsum     = $signed(ln_reg[0]) + $signed(ln_reg[1]) + $signed(ln_reg[2]);
        ndl_next = dln_reg[DLNW-1] ? '0 : dln_reg[NDLW-1:0];
        esum     = $signed(pe_reg[0]) + $signed(pe_reg[1]) + $signed(pe_reg[2]);
        dre      = esum[PEW+1:FRAC_BITS];
        // clamp R.E to [0, max]
        if (dre[DREW-1])
            red_next = '0;
        else if (dre[DREW-2:SATW] != '0)
            red_next = SAT_MAX;
        else
            red_next = dre[SATW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg  <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
            vp4_reg <= 1'b0;
            vp5_reg <= 1'b0;
            vp6_reg <= 1'b0;
        end
        else if (en)
        begin
            vl_reg  <= v_reg[QW];
            vp1_reg <= vl_reg;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vp4_reg <= vp3_reg;
            vp5_reg <= vp4_reg;
            vp6_reg <= vp5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg    <= l_next;
            dirl_reg <= dir_pipe[QW];
            for (int k = 0; k < 3; k++)
            begin
                ln_reg[k] <= ln_next[k];
                m_reg[k]  <= {m_prod[k], 1'b0};
                pe_reg[k] <= pe_next[k];
            end
            l1_reg   <= l_reg;
            dir1_reg <= dirl_reg;
            dln_reg  <= lsum[LNW+1:FRAC_BITS];
            l2_reg   <= l1_reg;
            dir2_reg <= dir1_reg;
            l3_reg   <= l2_reg;
            e3_reg   <= dir2_reg.e;
            ndl3_reg <= ndl_next;
            r_reg    <= r_next;
            e4_reg   <= e3_reg;
            ndl4_reg <= ndl3_reg;
            ndl5_reg <= ndl4_reg;
            red_reg  <= red_next;
            ndl6_reg <= ndl5_reg;
        end
    end

    assign out_valid = vp6_reg;
    assign red       = red_reg;
    assign ndl       = ndl6_reg;

endmodule

>>> rtl/core/ppls_pow.sv
// Specular power: one saturating Q2.14 multiply per stage, a stage passes its
// value through once the shininess count is reached. Uses ppls_pkg.
module ppls_pow
    import ppls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [SHIN_W-1:0] shininess,
    input  logic              in_valid,
    input  logic [SATW-1:0]   red,
    input  logic [NDLW-1:0]   ndl_in,
    output logic              out_valid,
    output logic [SATW-1:0]   factor,
    output logic [NDLW-1:0]   ndl_out
);

    logic            v_reg   [POW_STEPS];
    logic [SATW-1:0] f_reg   [POW_STEPS];
    logic [SATW-1:0] red_reg [POW_STEPS];
    logic [NDLW-1:0] ndl_reg [POW_STEPS];

    for (genvar k = 0; k < POW_STEPS; k++)
    begin : g_stage
        logic              v_src;
        logic [SATW-1:0]   f_src;
        logic [SATW-1:0]   red_src;
        logic [NDLW-1:0]   ndl_src;
        logic [2*SATW-1:0] prod;
        logic [SATW+1:0]   scaled;
        logic [SATW-1:0]   f_next;

        if (k == 0)
        begin : g_head
            assign v_src   = in_valid;
            assign f_src   = ONE_Q;
            assign red_src = red;
            assign ndl_src = ndl_in;
        end
        else
        begin : g_body
            assign v_src   = v_reg[k-1];
            assign f_src   = f_reg[k-1];
            assign red_src = red_reg[k-1];
            assign ndl_src = ndl_reg[k-1];
        end

        assign prod   = (2*SATW)'(f_src) * (2*SATW)'(red_src);
        assign scaled = prod[FRAC_BITS +: SATW+2];

        always_comb
        begin
            if (SHIN_W'(k) >= shininess)
                f_next = f_src;
            else if (scaled[SATW+1:SATW] != 2'b00)
                f_next = SAT_MAX;
            else
                f_next = scaled[SATW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[k]   <= f_next;
                red_reg[k] <= red_src;
                ndl_reg[k] <= ndl_src;
            end
        end
    end

    assign out_valid = v_reg[POW_STEPS-1];
    assign factor    = f_reg[POW_STEPS-1];
    assign ndl_out   = ndl_reg[POW_STEPS-1];

endmodule

>>> rtl/core/ppls_out.sv
// Diffuse and specular color terms, channel sum with saturation, and the
// output register with a skid slot that drives the pipeline enable. Uses ppls_pkg.
module ppls_out
    import ppls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  logic [SATW-1:0]    factor,
    input  logic [NDLW-1:0]    ndl,
    input  logic               out_stall,
    output logic               en,
    output logic               out_valid,
    output logic [2:0][CW-1:0] shade
);

    logic                   va_reg, vb_reg;
    logic [2:0][TW-1:0]     t_reg;
    logic [2:0][SPW-1:0]    s_reg, sb_reg;
    logic [2:0][DIFW-1:0]   dif_reg;
    logic [2:0][NDLW+EFFW-1:0] t_prod;
    logic [2:0][EFFW+SATW-1:0] s_prod;
    logic [2:0][TW+CW-1:0]  d_prod;
    logic [2:0][TOTW-1:0]   tot;
    logic [2:0][CW-1:0]     shade_next;

    logic               out_valid_reg, sk_valid_reg;
    logic [2:0][CW-1:0] shade_reg, sk_reg;

    assign en = !sk_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            t_prod[c] = (NDLW+EFFW)'(ndl) * (NDLW+EFFW)'(cfg.eff[c]);
            s_prod[c] = (EFFW+SATW)'(cfg.spg[c]) * (EFFW+SATW)'(factor);
            d_prod[c] = (TW+CW)'(t_reg[c]) * (TW+CW)'(cfg.diffuse);
            tot[c]    = TOTW'(cfg.amb[c]) + TOTW'(dif_reg[c]) + TOTW'(sb_reg[c]);
            shade_next[c] = (tot[c][TOTW-1:CW] != '0) ? OUT_MAX : tot[c][CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t_reg[c]   <= t_prod[c][FRAC_BITS +: TW];
                s_reg[c]   <= s_prod[c][FRAC_BITS +: SPW];
                dif_reg[c] <= d_prod[c][FRAC_BITS +: DIFW];
            end
            sb_reg <= s_reg;
        end
    end

    // output beat and skid slot; the pipeline holds only while the skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= vb_reg;
            else if (vb_reg)
                sk_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            sk_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!out_valid_reg || !out_stall)
                shade_reg <= shade_next;
            else
                sk_reg <= shade_next;
        end
        else if (!out_stall)
        begin
            shade_reg <= sk_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign shade     = shade_reg;

    a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sk_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled output beat");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (sk_valid_reg && !out_stall) |=> (!sk_valid_reg && out_valid_reg))
        else $error("skid did not move into the output register");

endmodule

>>> bench/phong_point_light_shading_tb.sv
// Self-checking bench for the point-light Phong shading pipeline.
// Depends on ppls_pkg and phong_point_light_shading; predicts each shaded color
// in fixed point and compares it beat by beat under random idling and stalls.
`timescale 1ns / 1ps

module phong_point_light_shading_tb;
    import ppls_pkg::*;

    typedef struct packed {
        logic [15:0] px, py, pz, nx, ny, nz, ex, ey, ez;
    } hit_t;

    typedef struct packed {
        logic [15:0] r, g, b;
    } rgb_t;

    localparam int LATENCY    = 308;
    localparam int WATCH_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] point_x = '0, point_y = '0, point_z = '0;
    logic [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic [15:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] shade_red, shade_green, shade_blue;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PAW-1:0] paddr = '0;
    logic [PDW-1:0] pwdata = '0;
    logic [PDW-1:0] prdata;
    logic pready;

    always #2 clk = ~clk;

    phong_point_light_shading i_dut (.*);

    // shading settings mirrored in the bench
    logic [47:0] light_pos, intensity, mat_color;
    logic [15:0] amb_gain, dif_gain, spec_gain;
    logic [7:0]  shininess;

    hit_t hit_queue[$];
    rgb_t shade_queue[$];
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_out = 1'b0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   drain_done = 1'b0;
    bit   in_taken = 1'b0;

    function automatic logic signed [63:0] floor_div(logic signed [63:0] v, int k);
        return v >>> k;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic rgb_t shade_point(hit_t h);
        logic signed [63:0] d[3], n[3], e[3], l[3], rv[3];
        logic signed [63:0] dln, dre;
        logic [63:0] sumsq, len, mag, refl, factor, inten, eff, amb, ndl, dif, spc, sum;
        logic [63:0] sat_q;
        logic [15:0] res[3];
        logic [15:0] pin[3], nin[3], ein[3];
        sat_q = (64'd4 << FRAC_BITS) - 1;
        pin = '{h.px, h.py, h.pz};
        nin = '{h.nx, h.ny, h.nz};
        ein = '{h.ex, h.ey, h.ez};
        sumsq = 0;
        dln = 0;
        dre = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = 64'(signed'(light_pos[16*k +: 16])) - 64'(signed'(pin[k]));
            n[k] = 64'(signed'(nin[k]));
            e[k] = 64'(signed'(ein[k]));
            sumsq += d[k] * d[k];
        end
        len = int_sqrt(sumsq << 16);
        for (int k = 0; k < 3; k++) begin
            if (len == 0) l[k] = 0;
            else begin
                mag = d[k] < 0 ? -d[k] : d[k];
                l[k] = (mag << (FRAC_BITS + POS_FRAC)) / len;
                if (d[k] < 0) l[k] = -l[k];
            end
            dln += l[k] * n[k];
        end
        dln = floor_div(dln, FRAC_BITS);
        for (int k = 0; k < 3; k++) begin
            rv[k] = -l[k] + floor_div(2 * n[k] * dln, FRAC_BITS);
            dre += rv[k] * e[k];
        end
        dre = floor_div(dre, FRAC_BITS);
        refl = dre < 0 ? 0 : dre;
        if (refl > sat_q) refl = sat_q;
        factor = 64'd1 << FRAC_BITS;
        for (int i = 0; i < shininess; i++) begin
            factor = (factor * refl) >> FRAC_BITS;
            if (factor > sat_q) factor = sat_q;
        end
        ndl = dln < 0 ? 0 : dln;
        for (int k = 0; k < 3; k++) begin
            inten = intensity[16*k +: 16];
            eff = (64'(mat_color[16*k +: 16]) * inten) >> FRAC_BITS;
            amb = (eff * amb_gain) >> FRAC_BITS;
            dif = (((ndl * eff) >> FRAC_BITS) * dif_gain) >> FRAC_BITS;
            spc = (((inten * spec_gain) >> FRAC_BITS) * factor) >> FRAC_BITS;
            sum = amb + dif + spc;
            res[k] = sum > 64'hFFFF ? 16'hFFFF : sum[15:0];
        end
        return '{r: res[0], g: res[1], b: res[2]};
    endfunction

    // driver: offer the head of the queue, advance on acceptance
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken) void'(hit_queue.pop_front());
            if (!in_valid || in_taken) begin
                if (hit_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    {point_x, point_y, point_z, normal_x, normal_y, normal_z,
                     eye_x, eye_y, eye_z} <= hit_queue[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= hold_out || ($urandom_range(99) < stall_pct);
        end
    end

    // note the accepting edge for the driver; predict on acceptance
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            shade_queue.push_back(shade_point({point_x, point_y, point_z, normal_x,
                                               normal_y, normal_z, eye_x, eye_y, eye_z}));
    end

    // monitor
    always @(posedge clk) begin
        rgb_t exp_c;
        if (rst_n && out_valid && !out_stall) begin
            if (shade_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected shade beat %h %h %h",
                                               shade_red, shade_green, shade_blue);
            end else begin
                exp_c = shade_queue.pop_front();
                if (exp_c.r !== shade_red || exp_c.g !== shade_green
                    || exp_c.b !== shade_blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("shade mismatch: expected %h %h %h got %h %h %h",
                                 exp_c.r, exp_c.g, exp_c.b,
                                 shade_red, shade_green, shade_blue);
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || drain_done
            || !rst_n)
            idle_cycles <= 0;
        else if (hit_queue.size() > 0 || shade_queue.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PAW'(8 * int'(idx)); pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LIGHT_POS: light_pos = value[47:0];
            REG_INTENSITY: intensity = value[47:0];
            REG_COLOR:     mat_color = value[47:0];
            REG_AMBIENT:   amb_gain = value[15:0];
            REG_DIFFUSE:   dif_gain = value[15:0];
            REG_SPECULAR:  spec_gain = value[15:0];
            REG_SHININESS: shininess = value[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (hit_queue.size() > 0 || shade_queue.size() > 0) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_unit();
        // mostly near-unit components, sometimes any value
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(32767) - 16384) ;
    endfunction

    function automatic hit_t rand_hit();
        hit_t h;
        h.px = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4095) - 2048);
        h.py = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4095) - 2048);
        h.pz = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4095) - 2048);
        h.nx = rand_unit(); h.ny = rand_unit(); h.nz = rand_unit();
        h.ex = rand_unit(); h.ey = rand_unit(); h.ez = rand_unit();
        // reflect-friendly case: eye along normal
        if ($urandom_range(3) == 0) begin
            h.ex = h.nx; h.ey = h.ny; h.ez = h.nz;
        end
        return h;
    endfunction

    function automatic logic [47:0] rand_triple();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic random_batch(int count);
        for (int i = 0; i < count; i++) hit_queue.push_back(rand_hit());
    endtask

    initial begin
        light_pos = RST_LIGHT_POS; intensity = RST_UNIT3; mat_color = RST_UNIT3;
        amb_gain = RST_AMBIENT; dif_gain = RST_DIFFUSE; spec_gain = RST_SPECULAR;
        shininess = RST_SHININESS;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, light at the point, extremes
        hit_queue.push_back('{default: 16'h0});
        hit_queue.push_back('{px: 16'h0, py: 16'h0, pz: 16'h0, nx: 16'h4000, ny: 0, nz: 0,
                              ex: 16'h4000, ey: 0, ez: 0});
        hit_queue.push_back('{px: 16'h8000, py: 16'h8000, pz: 16'h8000, nx: 0, ny: 16'h4000,
                              nz: 0, ex: 0, ey: 16'h4000, ez: 0});
        hit_queue.push_back('{default: 16'h7FFF});
        hit_queue.push_back('{default: 16'h8000});
        hit_queue.push_back('{default: 16'hFFFF});
        hit_queue.push_back('{px: 16'h7FFF, py: 16'h8000, pz: 16'h0001, nx: 16'h8000,
                              ny: 16'h7FFF, nz: 16'h0, ex: 16'h7FFF, ey: 16'h8000,
                              ez: 16'hFFFF});
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        write_reg(REG_LIGHT_POS, {16'h0A00, 16'h0500, 16'hFB00});
        write_reg(REG_SHININESS, 64'd1);
        write_reg(REG_SPECULAR, 64'hFFFF);
        write_reg(REG_DIFFUSE, 64'hFFFF);
        write_reg(REG_AMBIENT, 64'hFFFF);
        write_reg(REG_INTENSITY, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_COLOR, 48'hFFFF_FFFF_FFFF);
        hit_queue.push_back('{px: 16'h0000, py: 16'h0000, pz: 16'h0000, nx: 16'h0, ny: 16'h0,
                              nz: 16'h4000, ex: 16'h0, ey: 16'h0, ez: 16'h4000});
        hit_queue.push_back('{px: 16'hFB00, py: 16'h0500, pz: 16'h0A00, nx: 16'h4000,
                              ny: 0, nz: 0, ex: 16'h4000, ey: 0, ez: 0});
        random_batch(10);
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            write_reg(REG_LIGHT_POS, rand_triple());
            write_reg(REG_INTENSITY, ph == 1 ? 48'h0 : rand_triple());
            write_reg(REG_COLOR, rand_triple());
            write_reg(REG_AMBIENT, ph == 1 ? 64'h0 : 64'($urandom_range(65535)));
            write_reg(REG_DIFFUSE, 64'($urandom_range(65535)));
            write_reg(REG_SPECULAR, 64'($urandom_range(65535)));
            write_reg(REG_SHININESS, ph == 2 ? 64'd255 : ph == 3 ? 64'd0
                                                : 64'($urandom_range(255, 1)));
            // the first batch outnumbers the pipeline depth so the input stalls
            random_batch(ph == 0 ? 360 : 180);
            if (ph == 0) begin
                // long receiver hold-off while the sender keeps offering
                hold_out = 1'b1;
                repeat (600) @(posedge clk);
                hold_out = 1'b0;
            end
            wait_drained();
            repeat (LATENCY) @(posedge clk);
        end

        drain_done = 1'b1;
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ppls_pkg.sv
rtl/core/ppls_cfg.sv
rtl/core/ppls_norm.sv
rtl/core/ppls_dir.sv
rtl/core/ppls_pow.sv
rtl/core/ppls_out.sv
rtl/core/phong_point_light_shading.sv
bench/phong_point_light_shading_tb.sv
